// ===== rtl/core/shm_pkg.sv =====
// Shared types and constants for the space-time hit merger.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package shm_pkg;

  // Hit table geometry
  localparam int unsigned MAX_HITS = 64;
  localparam int unsigned IDX_W    = $clog2(MAX_HITS);
  localparam int unsigned CNT_W    = $clog2(MAX_HITS + 1);
  localparam int unsigned SLOT_W   = 6;

  // Weighted average datapath
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned DEN_W  = 33;
  localparam int unsigned QUO_W  = 40;
  localparam int unsigned WIDE_W = 42;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIME_WINDOW = 2'd0;
  localparam logic [1:0] CFG_MERGE_DIST  = 2'd1;

  // Item function codes
  localparam logic FUNC_DEPOSIT     = 1'b0;
  localparam logic FUNC_EVENT_START = 1'b1;

  typedef logic signed [23:0] coord_t;

  typedef struct packed {
    logic               func;
    logic [23:0]        deposit_energy;
    logic [15:0]        copy_number;
    logic [39:0]        entry_time;
    logic [39:0]        exit_time;
    logic signed [23:0] entry_x;
    logic signed [23:0] entry_y;
    logic signed [23:0] entry_z;
    logic signed [23:0] exit_x;
    logic signed [23:0] exit_y;
    logic signed [23:0] exit_z;
  } item_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic               merged;
    logic               table_full;
    logic [31:0]        hit_energy;
    logic [39:0]        hit_time;
    logic signed [23:0] hit_x;
    logic signed [23:0] hit_y;
    logic signed [23:0] hit_z;
    logic [15:0]        hit_copy;
  } result_t;

  // One hit table entry
  typedef struct packed {
    logic [31:0]      energy;
    logic [39:0]      hit_time;
    coord_t [2:0]     pos;
    logic [15:0]      copy;
  } entry_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
    logic             frac;
  } div_rsp_t;

  function automatic logic signed [WIDE_W-1:0] sext_coord(coord_t c);
    return {{(WIDE_W-24){c[23]}}, c};
  endfunction

endpackage

// ===== rtl/core/shm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on shm_pkg; quotient must fit QUO_W bits (num < den << QUO_W).
`timescale 1ns / 1ps

module shm_div
  import shm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             run_q, run_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;

  // One shift-subtract step per cycle
  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[QUO_W-1]};
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = 6'(QUO_W);
      rem_d = DEN_W'(req_i.num[NUM_W-1:QUO_W]);
      quo_d = req_i.num[QUO_W-1:0];
      den_d = req_i.den;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.frac = (rem_q != '0);

endmodule

// ===== rtl/core/spacetime_hit_merger_top.sv =====
// Space-time hit merger: sequencer, hit table memory, shared multiplier.
// Depends on shm_pkg and shm_div.
`timescale 1ns / 1ps

// One deposit beat at a time: busy is high from acceptance until the result
// strobe. A start-of-event or zero-energy item gives no result. A deposit
// squares the merge distance (S_LIM, S_LIMW), then reads each table entry
// (S_RD, S_CHK); one within the time window goes to the distance test
// (S_SQ, S_SQE). On a merge, time, x, y and z each pass S_DIFF, S_MUL0 to
// S_MUL2, the 40-step divider (S_DIV) and S_FIX; a deposit ends in S_FIN.
// The scan reads the hit table one entry per access. The result strobe lasts
// one cycle and cannot be held off; configuration writes are always ready.

module spacetime_hit_merger_top
  import shm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  item_t       item_i,
  output logic        result_valid_o,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_LIM  = 14'b00000000000010,
    S_LIMW = 14'b00000000000100,
    S_RD   = 14'b00000000001000,
    S_CHK  = 14'b00000000010000,
    S_SQ   = 14'b00000000100000,
    S_SQE  = 14'b00000001000000,
    S_DIFF = 14'b00000010000000,
    S_MUL0 = 14'b00000100000000,
    S_MUL1 = 14'b00001000000000,
    S_MUL2 = 14'b00010000000000,
    S_DIV  = 14'b00100000000000,
    S_FIX  = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_e;

  state_e st_q, st_d;

  // Configuration registers
  logic [31:0] tw_q;
  logic [22:0] md_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q <= 32'd1000;
      md_q <= 23'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIME_WINDOW: tw_q <= cfg_data_i;
        CFG_MERGE_DIST:  md_q <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // Item registers
  logic [23:0]      e_q;
  logic [15:0]      copy_q;
  logic [39:0]      t_mid_q;
  coord_t [2:0]     pos_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [1:0]       k_q, k_d;
  logic [1:0]       c_q, c_d;
  logic [45:0]      lim2_q;
  logic [49:0]      acc_q, acc_d;
  logic [49:0]      prod_q;
  logic             match_q, match_d;
  logic [DEN_W-1:0] tot_q;
  logic signed [WIDE_W-1:0] base_q;
  logic             neg_q;
  logic [39:0]      mag_q;
  logic [NUM_W-1:0] num_q, num_d;
  logic [39:0]      new_time_q;
  coord_t [2:0]     new_pos_q;

  // Hit table
  entry_t           mem [MAX_HITS];
  entry_t           rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  // Midpoints of the incoming beat
  logic [40:0]        t_sum;
  logic signed [24:0] p_sum [3];
  logic signed [24:0] p_adj [3];
  coord_t [2:0]       pos_in;

  always_comb begin
    t_sum    = {1'b0, item_i.entry_time} + {1'b0, item_i.exit_time};
    p_sum[0] = {item_i.entry_x[23], item_i.entry_x} + {item_i.exit_x[23], item_i.exit_x};
    p_sum[1] = {item_i.entry_y[23], item_i.entry_y} + {item_i.exit_y[23], item_i.exit_y};
    p_sum[2] = {item_i.entry_z[23], item_i.entry_z} + {item_i.exit_z[23], item_i.exit_z};
    for (int i = 0; i < 3; i++) begin
      // truncate toward zero
      p_adj[i]  = p_sum[i] + {24'd0, p_sum[i][24]};
      pos_in[i] = p_adj[i][24:1];
    end
  end

  // Scan compare terms
  logic [39:0]        dt;
  logic signed [24:0] sq_diff;
  logic [24:0]        sq_mag;
  logic [49:0]        d2_sum;
  logic               last_entry;

  always_comb begin
    dt = (t_mid_q >= rd_q.hit_time) ? t_mid_q - rd_q.hit_time : rd_q.hit_time - t_mid_q;
    sq_diff = {pos_q[k_q][23], pos_q[k_q]} - {rd_q.pos[k_q][23], rd_q.pos[k_q]};
    sq_mag  = sq_diff[24] ? 25'(-sq_diff) : 25'(sq_diff);
    d2_sum  = acc_q + prod_q;
    last_entry = ((idx_q + CNT_W'(1)) >= count_q);
  end

  // Component difference for the weighted average
  logic signed [WIDE_W-1:0] w_base, w_p, w_diff, w_neg;

  always_comb begin
    if (c_q == 2'd0) begin
      w_base = {2'b00, rd_q.hit_time};
      w_p    = {2'b00, t_mid_q};
    end else begin
      w_base = sext_coord(rd_q.pos[c_q - 2'd1]);
      w_p    = sext_coord(pos_q[c_q - 2'd1]);
    end
    w_diff = w_p - w_base;
    w_neg  = -w_diff;
  end

  // Shared multiplier, registered output
  logic [24:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      S_LIM: begin
        mul_a = {2'b00, md_q};
        mul_b = {2'b00, md_q};
      end
      S_SQ: begin
        mul_a = sq_mag;
        mul_b = sq_mag;
      end
      S_MUL0: begin
        mul_a = {1'b0, e_q};
        mul_b = {5'd0, mag_q[19:0]};
      end
      S_MUL1: begin
        mul_a = {1'b0, e_q};
        mul_b = {5'd0, mag_q[39:20]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign num_d = num_q + {prod_q[43:0], 20'd0};

  always_comb begin
    div_req.start = (st_q == S_MUL2);
    div_req.num   = num_d;
    div_req.den   = tot_q;
  end

  shm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Rounding fix of the weighted value
  logic signed [WIDE_W-1:0] f_raw, f_val;

  always_comb begin
    if (neg_q) begin
      f_raw = base_q - {2'b00, div_rsp.quot} - {{(WIDE_W-1){1'b0}}, div_rsp.frac};
    end else begin
      f_raw = base_q + {2'b00, div_rsp.quot};
    end
    f_val = (f_raw[WIDE_W-1] && div_rsp.frac) ? f_raw + WIDE_W'(1) : f_raw;
  end

  // Sequencer
  always_comb begin
    st_d    = st_q;
    count_d = count_q;
    idx_d   = idx_q;
    k_d     = k_q;
    c_d     = c_q;
    acc_d   = acc_q;
    match_d = match_q;
    mem_re  = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (start) begin
          if (item_i.func == FUNC_EVENT_START) begin
            count_d = '0;
          end else if (item_i.deposit_energy != '0) begin
            idx_d   = '0;
            match_d = 1'b0;
            st_d    = S_LIM;
          end
        end
      end
      S_LIM:  st_d = S_LIMW;
      S_LIMW: st_d = (count_q == '0) ? S_FIN : S_RD;
      S_RD: begin
        mem_re = 1'b1;
        st_d   = S_CHK;
      end
      S_CHK: begin
        if (dt > {8'd0, tw_q}) begin
          idx_d = idx_q + CNT_W'(1);
          st_d  = last_entry ? S_FIN : S_RD;
        end else begin
          k_d   = '0;
          acc_d = '0;
          st_d  = S_SQ;
        end
      end
      S_SQ: begin
        acc_d = (k_q != 2'd0) ? acc_q + prod_q : acc_q;
        k_d   = k_q + 2'd1;
        if (k_q == 2'd2) begin
          st_d = S_SQE;
        end
      end
      S_SQE: begin
        if (d2_sum <= {4'd0, lim2_q}) begin
          match_d = 1'b1;
          c_d     = '0;
          st_d    = S_DIFF;
        end else begin
          idx_d = idx_q + CNT_W'(1);
          st_d  = last_entry ? S_FIN : S_RD;
        end
      end
      S_DIFF: st_d = S_MUL0;
      S_MUL0: st_d = S_MUL1;
      S_MUL1: st_d = S_MUL2;
      S_MUL2: st_d = S_DIV;
      S_DIV:  st_d = div_rsp.done ? S_FIX : S_DIV;
      S_FIX: begin
        c_d  = c_q + 2'd1;
        st_d = (c_q == 2'd3) ? S_FIN : S_DIFF;
      end
      S_FIN: begin
        if (!match_q && (count_q < CNT_W'(MAX_HITS))) begin
          count_d = count_q + CNT_W'(1);
        end
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      k_q     <= '0;
      c_q     <= '0;
      match_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      c_q     <= c_d;
      match_q <= match_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (st_q == S_IDLE) begin
      e_q     <= item_i.deposit_energy;
      copy_q  <= item_i.copy_number;
      t_mid_q <= t_sum[40:1];
      pos_q   <= pos_in;
    end
    if (st_q == S_LIMW) begin
      lim2_q <= prod_q[45:0];
    end
    if (st_q == S_SQE) begin
      tot_q <= {9'd0, e_q} + {1'b0, rd_q.energy};
    end
    if (st_q == S_DIFF) begin
      base_q <= w_base;
      neg_q  <= w_diff[WIDE_W-1];
      mag_q  <= w_diff[WIDE_W-1] ? w_neg[39:0] : w_diff[39:0];
    end
    if (st_q == S_MUL1) begin
      num_q <= {20'd0, prod_q[43:0]};
    end
    if (st_q == S_FIX) begin
      if (c_q == 2'd0) begin
        new_time_q <= f_val[39:0];
      end else begin
        new_pos_q[c_q - 2'd1] <= f_val[23:0];
      end
    end
  end

  // Table write and result
  logic        fin_new, fin_full;
  logic [31:0] sat_energy;
  result_t     res_d, res_q;
  logic        res_vld_q;

  always_comb begin
    fin_new    = !match_q && (count_q < CNT_W'(MAX_HITS));
    fin_full   = !match_q && !fin_new;
    sat_energy = tot_q[DEN_W-1] ? '1 : tot_q[31:0];
    mem_we     = (st_q == S_FIN) && !fin_full;
    if (match_q) begin
      mem_waddr = idx_q[IDX_W-1:0];
      mem_wdata = '{energy: sat_energy, hit_time: new_time_q, pos: new_pos_q, copy: copy_q};
    end else begin
      mem_waddr = count_q[IDX_W-1:0];
      mem_wdata = '{energy: {8'd0, e_q}, hit_time: t_mid_q, pos: pos_q, copy: copy_q};
    end
    res_d = '0;
    if (fin_full) begin
      res_d.table_full = 1'b1;
    end else begin
      res_d.slot       = SLOT_W'(mem_waddr);
      res_d.merged     = match_q;
      res_d.hit_energy = mem_wdata.energy;
      res_d.hit_time   = mem_wdata.hit_time;
      res_d.hit_x      = mem_wdata.pos[0];
      res_d.hit_y      = mem_wdata.pos[1];
      res_d.hit_z      = mem_wdata.pos[2];
      res_d.hit_copy   = mem_wdata.copy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= (st_q == S_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_FIN) begin
      res_q <= res_d;
    end
  end

  assign busy           = (st_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ===== rtl/core/shm_checker.sv =====
// Port-level checks for the space-time hit merger, bound to the top level.
// Depends on shm_pkg and spacetime_hit_merger_top.
`timescale 1ns / 1ps

module shm_checker
  import shm_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input item_t       item_i,
  input logic        result_valid_o,
  input result_t     result_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  // A beat that clears the table or carries no energy leaves no result
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.func == FUNC_EVENT_START || item_i.deposit_energy == '0))
      |=> (!busy && !result_valid_o))
    else $error("shm: cleared or empty beat produced work");

  // A real deposit occupies the block
  a_dep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.func == FUNC_DEPOSIT && item_i.deposit_energy != '0)
      |=> busy)
    else $error("shm: deposit not taken up");

  // The block is free again when its result shows, and results never repeat
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (!busy ##1 !result_valid_o))
    else $error("shm: result while busy or repeated");

  // A dropped deposit reports an empty hit, a kept one carries energy
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.table_full
      ? (!result_o.merged && result_o.hit_energy == '0 && result_o.slot == '0)
      : (result_o.hit_energy != '0)))
    else $error("shm: result energy inconsistent with table_full");

endmodule

bind spacetime_hit_merger_top shm_checker u_shm_checker (.*);
